### src/sitoa_pkg.sv
package sitoa_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned CntWidth   = $clog2(ValueWidth);
  localparam int unsigned DigWidth   = $clog2(NumDigits + 1);

  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic neg;
    logic top_zero;
    logic one_left;
  } sts_t;

endpackage

### src/sitoa_datapath.sv
module sitoa_datapath
  import sitoa_pkg::*;
(
  input  logic                  clk_i,
  input  cmd_t                  cmd_i,
  input  logic [ValueWidth-1:0] value_i,
  output sts_t                  sts_o,
  output logic [7:0]            character_o,
  output logic                  last_o
);

  logic [ValueWidth-1:0] mag_q, mag_d;
  logic [BcdWidth-1:0]   bcd_q, bcd_d;
  logic [BcdWidth-1:0]   bcd_adj;
  logic [DigWidth-1:0]   ndig_q, ndig_d;
  logic                  neg_q, neg_d;
  logic [3:0]            top_digit;

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign top_digit = bcd_q[BcdWidth-1 -: 4];

  always_comb begin
    mag_d  = mag_q;
    bcd_d  = bcd_q;
    ndig_d = ndig_q;
    neg_d  = neg_q;
    if (cmd_i.load) begin
      neg_d  = value_i[ValueWidth-1];
      mag_d  = value_i[ValueWidth-1] ? (~value_i + 1'b1) : value_i;
      bcd_d  = '0;
      ndig_d = DigWidth'(NumDigits);
    end else if (cmd_i.shift) begin
      bcd_d = {bcd_adj[BcdWidth-2:0], mag_q[ValueWidth-1]};
      mag_d = {mag_q[ValueWidth-2:0], 1'b0};
    end else if (cmd_i.skip || cmd_i.emit_digit) begin
      bcd_d  = {bcd_q[BcdWidth-5:0], 4'd0};
      ndig_d = ndig_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    ndig_q <= ndig_d;
    neg_q  <= neg_d;
  end

  assign sts_o.neg      = neg_q;
  assign sts_o.top_zero = (top_digit == 4'd0);
  assign sts_o.one_left = (ndig_q == DigWidth'(1));

  assign character_o = cmd_i.emit_sign ? CharMinus : (CharZero + {4'd0, top_digit});
  assign last_o      = cmd_i.emit_digit && (ndig_q == DigWidth'(1));

endmodule

### src/sitoa_ctrl.sv
module sitoa_ctrl
  import sitoa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy,
  output logic strobe_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StConv = 3'd1;
  localparam logic [2:0] StSkip = 3'd2;
  localparam logic [2:0] StSign = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.shift = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == CntWidth'(ValueWidth - 1)) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        // drop leading zeros, keep at least one digit
        if (sts_i.top_zero && !sts_i.one_left) begin
          cmd_o.skip = 1'b1;
        end else if (sts_i.neg) begin
          state_d = StSign;
        end else begin
          state_d = StEmit;
        end
      end
      StSign: begin
        cmd_o.emit_sign = 1'b1;
        state_d         = StEmit;
      end
      StEmit: begin
        cmd_o.emit_digit = 1'b1;
        if (sts_i.one_left) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy     = (state_q != StIdle);
  assign strobe_o = cmd_o.emit_sign || cmd_o.emit_digit;

endmodule

### src/signed_int_to_decimal_ascii.sv
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+---------------------------
// command  | in        | start & !busy      | value_i[31:0] signed
// result   | out       | strobe_o (1 cycle) | character_o[7:0], last_o
//
// from accept to the next accept, an item runs the shift-and-add-3 steps of
// the bcd converter, drops one leading zero digit per cycle, takes one
// decision step, then emits a minus sign if negative and one character per
// cycle. busy stays high from the accept through the last character.
// rst_ni clears the controller only; the datapath needs no reset.
// the receiver cannot stall: each character is shown for exactly one cycle.
module signed_int_to_decimal_ascii
  import sitoa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [ValueWidth-1:0] value_i,
  output logic                  strobe_o,
  output logic [7:0]            character_o,
  output logic                  last_o
);

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: load, 32 shifts, zero skip, sign, digits
  sitoa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy),
    .strobe_o (strobe_o)
  );

  // magnitude, double-dabble bcd register and digit count
  sitoa_datapath u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .value_i     (value_i),
    .sts_o       (sts),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule
